// ===== rtl/plx_pkg.sv =====
// Shared types, constants and codes of the piecewise linear interpolator.
`default_nettype none
package plx_pkg;

  localparam int MAX_POINTS = 16;
  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);
  localparam int FRAC_W     = 17;   // Q1.16 fraction, 1.0 included

  localparam logic [1:0] OP_SET   = 2'd0;
  localparam logic [1:0] OP_QUERY = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_DIV,
    ST_MUL,
    ST_ADD,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic [1:0]         opcode;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] result_y;
    logic               has_value;
    logic               insert_dropped;
  } out_word_t;

  // Write command broadcast along the row of breakpoint cells
  typedef struct packed {
    logic             ins;
    logic             ovw;
    logic [IDX_W-1:0] pos;
  } cell_ctl_t;

endpackage
`default_nettype wire

// ===== rtl/plx_cell.sv =====
// One breakpoint cell of the sorted table: holds an (x, y) pair.
`default_nettype none
module plx_cell
  import plx_pkg::*;
(
  input  wire logic               clk,
  input  wire logic [IDX_W-1:0]   idx,
  input  wire cell_ctl_t          ctl,
  input  wire logic signed [31:0] new_x,
  input  wire logic signed [31:0] new_y,
  input  wire logic signed [31:0] up_x,
  input  wire logic signed [31:0] up_y,
  output logic signed [31:0]      x,
  output logic signed [31:0]      y
);

  logic signed [31:0] x_r;
  logic signed [31:0] y_r;

  // Cells above the insert slot shift up, slot loads; ovw sets y only
  always_ff @(posedge clk) begin
    if (ctl.ins && (idx > ctl.pos)) begin
      x_r <= up_x;
      y_r <= up_y;
    end else if (ctl.ins && (idx == ctl.pos)) begin
      x_r <= new_x;
      y_r <= new_y;
    end else if (ctl.ovw && (idx == ctl.pos)) begin
      y_r <= new_y;
    end
  end

  assign x = x_r;
  assign y = y_r;

endmodule
`default_nettype wire

// ===== rtl/plx_divider.sv =====
// Restoring divider giving the Q1.16 segment fraction, one bit a cycle.
`default_nettype none
module plx_divider
  import plx_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [31:0]       num,
  input  wire logic [31:0]       den,
  output logic                   done,
  output logic [FRAC_W-1:0]      quo
);

  logic              busy_r;
  logic              done_r;
  logic [4:0]        cnt_r;
  logic [31:0]       rem_r;
  logic [31:0]       den_r;
  logic [FRAC_W-1:0] bits_r;
  logic [FRAC_W-1:0] quo_r;
  logic [32:0]       trial;
  logic              ge;
  logic [32:0]       diff;

  // Trial subtract of the next dividend bit
  always_comb begin
    trial = {rem_r, bits_r[FRAC_W-1]};
    ge    = trial >= {1'b0, den_r};
    diff  = trial - {1'b0, den_r};
  end

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 5'(FRAC_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 5'd1;
        if (cnt_r == 5'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath: dividend is num * 2^16, quotient fits in 17 bits
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= {1'b0, num[31:1]};
      bits_r <= {num[0], 16'd0};
      den_r  <= den;
    end else if (busy_r) begin
      rem_r  <= ge ? diff[31:0] : trial[31:0];
      bits_r <= {bits_r[FRAC_W-2:0], 1'b0};
      quo_r  <= {quo_r[FRAC_W-2:0], ge};
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule
`default_nettype wire

// ===== rtl/piecewise_linear_interpolator.sv =====
// Top level: breakpoint cell row, table walk sequencer and interpolation.
// Sequence: set and query words walk the table, one cell a cycle, up to the first
//   breakpoint not below x; interpolated queries then run the fraction divider, the
//   multiply and the add. A clear empties the table without a walk.
// Throughput: one word at a time; a new word is taken only when the previous is finished.
// Reset: synchronous active-low rst_n empties the table and clears out_valid.
`default_nettype none
module piecewise_linear_interpolator
  import plx_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_word_t  in_word,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_word_t      out_word
);

  state_t state_r, state_nxt;

  logic [CNT_W-1:0]   count_r;
  logic [CNT_W-1:0]   cursor_r;
  logic [1:0]         op_r;
  logic signed [31:0] x_r, y_r;
  logic signed [31:0] prev_x_r, prev_y_r;
  logic signed [31:0] y0_r;
  logic signed [32:0] dy_r;
  logic signed [50:0] prod_r;
  out_word_t          res_r;
  logic               out_valid_r;
  out_word_t          out_word_r;

  logic signed [31:0] cell_x [MAX_POINTS];
  logic signed [31:0] cell_y [MAX_POINTS];
  logic signed [31:0] cur_x, cur_y;
  logic               at_end, hit, exact;
  cell_ctl_t          ctl;
  logic               div_start, div_done;
  logic [FRAC_W-1:0]  frac;
  logic [31:0]        div_num, div_den;
  logic               take, out_free;

  // Row of breakpoint cells
  for (genvar i = 0; i < MAX_POINTS; i++) begin : g_cell
    if (i == 0) begin : g_first
      plx_cell u_cell (
        .clk(clk), .idx(IDX_W'(i)), .ctl(ctl),
        .new_x(x_r), .new_y(y_r),
        .up_x(cell_x[0]), .up_y(cell_y[0]),
        .x(cell_x[i]), .y(cell_y[i])
      );
    end else begin : g_rest
      plx_cell u_cell (
        .clk(clk), .idx(IDX_W'(i)), .ctl(ctl),
        .new_x(x_r), .new_y(y_r),
        .up_x(cell_x[i-1]), .up_y(cell_y[i-1]),
        .x(cell_x[i]), .y(cell_y[i])
      );
    end
  end

  plx_divider u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start),
    .num(div_num), .den(div_den), .done(div_done), .quo(frac)
  );

  // Walk: cell under the cursor, stop at the first x not below the key or at the table end
  always_comb begin
    cur_x   = cell_x[cursor_r[IDX_W-1:0]];
    cur_y   = cell_y[cursor_r[IDX_W-1:0]];
    at_end  = cursor_r == count_r;
    hit     = at_end || (cur_x >= x_r);
    exact   = !at_end && (cur_x == x_r);
    div_num = 32'(x_r - prev_x_r);
    div_den = 32'(cur_x - prev_x_r);
  end

  assign take     = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  // Next state and cell commands
  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    ctl.pos   = cursor_r[IDX_W-1:0];
    div_start = 1'b0;
    in_stall  = state_r != ST_IDLE;
    unique case (state_r)
      ST_IDLE: if (take) state_nxt = ST_WALK;
      ST_WALK: begin
        if (op_r == OP_CLEAR || (op_r != OP_SET && op_r != OP_QUERY)) begin
          state_nxt = ST_FIN;
        end else if (op_r == OP_QUERY && count_r == '0) begin
          state_nxt = ST_FIN;
        end else if (hit) begin
          state_nxt = ST_FIN;
          if (op_r == OP_SET) begin
            ctl.ovw = exact;
            ctl.ins = !exact && (count_r != CNT_W'(MAX_POINTS));
          end else if (cursor_r != '0 && !at_end) begin
            div_start = 1'b1;
            state_nxt = ST_DIV;
          end
        end
      end
      ST_DIV:  if (div_done) state_nxt = ST_MUL;
      ST_MUL:  state_nxt = ST_ADD;
      ST_ADD:  state_nxt = ST_FIN;
      ST_FIN:  if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  // Table count and walk cursor
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      cursor_r <= '0;
    end else begin
      if (state_r == ST_IDLE) cursor_r <= '0;
      else if (state_r == ST_WALK && !hit) cursor_r <= cursor_r + CNT_W'(1);
      if (state_r == ST_WALK && op_r == OP_CLEAR) count_r <= '0;
      else if (ctl.ins) count_r <= count_r + CNT_W'(1);
    end
  end

  // Item capture, walk history and arithmetic
  always_ff @(posedge clk) begin
    if (take) begin
      op_r  <= in_word.opcode;
      x_r   <= in_word.coord_x;
      y_r   <= in_word.coord_y;
      res_r <= '0;
    end
    if (state_r == ST_WALK) begin
      if (!hit) begin
        prev_x_r <= cur_x;
        prev_y_r <= cur_y;
      end else if (op_r == OP_SET) begin
        res_r.insert_dropped <= !exact && (count_r == CNT_W'(MAX_POINTS));
      end else if (op_r == OP_QUERY && count_r != '0) begin
        res_r.has_value <= 1'b1;
        res_r.result_y  <= (cursor_r == '0) ? cur_y : prev_y_r;
        y0_r            <= prev_y_r;
        dy_r            <= 33'(cur_y) - 33'(prev_y_r);
      end
    end
    if (state_r == ST_MUL) prod_r <= dy_r * $signed({1'b0, frac});
    if (state_r == ST_ADD) res_r.result_y <= y0_r + prod_r[47:16];
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_FIN && out_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_FIN && out_free) out_word_r <= res_r;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule
`default_nettype wire
